// ===== src/mcm_pkg.sv =====
// Shared types and constants for the matrix chain ordering block.
// Request and result structs, controller command/status bundles.
// No dependencies.
package mcm_pkg;

	localparam int DEF_MAX_MATRICES = 8;
	localparam int DEF_DIM_WIDTH    = 12;

	localparam int IN_DIM_W = 12;
	localparam int IDX_W    = 4;
	localparam int COST_W   = 40;

	localparam logic [COST_W-1:0] COST_MAX = '1;

	typedef struct packed {
		logic [IN_DIM_W-1:0] dim_value;
		logic                last_dim;
	} dim_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  row_index;
		logic [IDX_W-1:0]  col_index;
		logic [COST_W-1:0] min_cost;
		logic [IDX_W-1:0]  split_point;
		logic              size_error;
		logic              last_result;
	} result_t;

	// result flavor: a computed pair, or the lone result of a short/bad set
	typedef enum logic {
		RK_PAIR  = 1'b0,
		RK_SHORT = 1'b1
	} res_kind_t;

	typedef struct packed {
		logic             dim_we;
		logic [IDX_W-1:0] dim_addr;
		logic             di_load;
		logic             dj_load;
		logic             issue;
		logic             first;
		logic [IDX_W-1:0] row_idx;
		logic [IDX_W-1:0] col_idx;
		logic [IDX_W-1:0] split_idx;
		logic             cost_we;
		logic             out_load;
		res_kind_t        kind;
		logic             err;
		logic             last;
	} mcm_cmd_t;

	typedef struct packed {
		logic busy;
		logic out_free;
	} mcm_sts_t;

endpackage

// ===== src/mcm_dpath.sv =====
// Datapath: dimension store, cost table, multiply/add/compare pipeline
// and the result register. Driven by mcm_ctrl; uses mcm_pkg.
module mcm_dpath import mcm_pkg::*; #(
	parameter int MAX_MATRICES = DEF_MAX_MATRICES,
	parameter int DIM_WIDTH    = DEF_DIM_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mcm_cmd_t            cmd,
	output mcm_sts_t            sts,
	input  logic [IN_DIM_W-1:0] dim_value,
	input  logic                res_stall,
	output logic                res_valid,
	output result_t             res
);

	localparam int DDEPTH = MAX_MATRICES + 1;
	localparam int DA_W   = $clog2(DDEPTH);
	localparam int CDEPTH = MAX_MATRICES * MAX_MATRICES;
	localparam int CA_W   = $clog2(CDEPTH);
	localparam int P1W    = 2 * DIM_WIDTH;
	localparam int PW     = 3 * DIM_WIDTH;
	localparam int PXW    = (PW > COST_W) ? PW : COST_W + 1;

	function automatic logic [CA_W-1:0] caddr(input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c);
		caddr = CA_W'(r * MAX_MATRICES + c);
	endfunction

	function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
			input logic [COST_W-1:0] b);
		logic [COST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = s[COST_W] ? COST_MAX : s[COST_W-1:0];
	endfunction

	logic [DIM_WIDTH-1:0] dim_mem [DDEPTH];
	logic [DIM_WIDTH-1:0] dim_rd_q;
	logic [DIM_WIDTH-1:0] di_q, dj_q;

	logic [COST_W-1:0] cost_mem [CDEPTH];
	logic [COST_W-1:0] cost_a_s1, cost_b_s1;

	logic             valid_s1, valid_s2, valid_s3;
	logic             first_s1, first_s2, first_s3;
	logic             za_s1, zb_s1;
	logic [IDX_W-1:0] k_s1, k_s2, k_s3;
	logic [P1W-1:0]   prod1_s2;
	logic [PW-1:0]    prod2_s3;
	logic [COST_W-1:0] sum_s2, sum_s3;

	logic [COST_W-1:0] best_q;
	logic [IDX_W-1:0]  bk_q;

	logic [IDX_W-1:0]  k_next;
	logic [PXW-1:0]    prod_x;
	logic [COST_W-1:0] prod_sat, cand;

	assign k_next = cmd.split_idx + 1'b1;

	// dimension store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.dim_we)
			dim_mem[cmd.dim_addr[DA_W-1:0]] <= DIM_WIDTH'(dim_value);
		dim_rd_q <= dim_mem[cmd.dim_addr[DA_W-1:0]];
		if (cmd.di_load)
			di_q <= dim_rd_q;
		if (cmd.dj_load)
			dj_q <= dim_rd_q;
	end

	// cost table: written once per pair, read at (i,k) and (k+1,j)
	always_ff @(posedge clk) begin
		if (cmd.cost_we)
			cost_mem[caddr(cmd.row_idx, cmd.col_idx)] <= best_q;
		cost_a_s1 <= cost_mem[caddr(cmd.row_idx, cmd.split_idx)];
		cost_b_s1 <= cost_mem[caddr(k_next, cmd.col_idx)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// diagonal entries are never stored: zero flags stand in for them
	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		za_s1    <= (cmd.split_idx == cmd.row_idx);
		zb_s1    <= (k_next == cmd.col_idx);
		k_s1     <= cmd.split_idx;

		prod1_s2 <= P1W'(di_q) * P1W'(dim_rd_q);
		sum_s2   <= sat_add(za_s1 ? '0 : cost_a_s1, zb_s1 ? '0 : cost_b_s1);
		first_s2 <= first_s1;
		k_s2     <= k_s1;

		prod2_s3 <= PW'(prod1_s2) * PW'(dj_q);
		sum_s3   <= sum_s2;
		first_s3 <= first_s2;
		k_s3     <= k_s2;
	end

	always_comb begin
		prod_x   = PXW'(prod2_s3);
		prod_sat = (prod_x > PXW'(COST_MAX)) ? COST_MAX : prod_x[COST_W-1:0];
		cand     = sat_add(sum_s3, prod_sat);
	end

	// strict compare keeps the smallest k on ties
	always_ff @(posedge clk) begin
		if (valid_s3 && (first_s3 || cand < best_q)) begin
			best_q <= cand;
			bk_q   <= k_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid <= 1'b0;
		else if (cmd.out_load)
			res_valid <= 1'b1;
		else if (!res_stall)
			res_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.kind == RK_SHORT) begin
				res.row_index   <= '0;
				res.col_index   <= '0;
				res.min_cost    <= '0;
				res.split_point <= '0;
				res.size_error  <= cmd.err;
				res.last_result <= 1'b1;
			end else begin
				res.row_index   <= cmd.row_idx;
				res.col_index   <= cmd.col_idx;
				res.min_cost    <= best_q;
				res.split_point <= bk_q;
				res.size_error  <= 1'b0;
				res.last_result <= cmd.last;
			end
		end
	end

	assign sts.busy     = valid_s1 | valid_s2 | valid_s3;
	assign sts.out_free = !res_valid || !res_stall;

endmodule

// ===== src/mcm_ctrl.sv =====
// Controller: loads the dimension list, then walks diagonals, rows and
// split points, issuing commands to mcm_dpath. Uses mcm_pkg.
module mcm_ctrl import mcm_pkg::*; #(
	parameter int MAX_MATRICES = DEF_MAX_MATRICES
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     dim_valid,
	input  logic     last_dim,
	output logic     dim_stall,
	output mcm_cmd_t cmd,
	input  mcm_sts_t sts
);

	localparam int CNT_W = $clog2(MAX_MATRICES + 2);

	typedef enum logic [6:0] {
		ST_LOAD  = 7'b0000001,
		ST_SHORT = 7'b0000010,
		ST_DI    = 7'b0000100,
		ST_DJ    = 7'b0001000,
		ST_RUN   = 7'b0010000,
		ST_DRAIN = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic             err_q;
	logic [IDX_W-1:0] n_q, i_q, j_q, k_q, diag_q;

	logic acc, full, err_now;

	assign acc       = dim_valid && (state_q == ST_LOAD);
	assign dim_stall = (state_q != ST_LOAD);
	assign full      = (cnt_q == CNT_W'(MAX_MATRICES + 1));
	// a request arriving with the store full also counts as overflow
	assign err_now   = ovf_q || full || (cnt_q == '0);

	always_comb begin
		cmd           = '0;
		cmd.kind      = RK_PAIR;
		cmd.row_idx   = i_q;
		cmd.col_idx   = j_q;
		cmd.split_idx = k_q;
		cmd.err       = err_q;
		cmd.last      = (diag_q == n_q - 1'b1);
		case (state_q)
			ST_LOAD: begin
				cmd.dim_we   = acc && !full;
				cmd.dim_addr = IDX_W'(cnt_q);
			end
			ST_SHORT: begin
				cmd.out_load = sts.out_free;
				cmd.kind     = RK_SHORT;
			end
			ST_DI: begin
				cmd.dim_addr = i_q;
			end
			ST_DJ: begin
				cmd.dim_addr = j_q + 1'b1;
				cmd.di_load  = 1'b1;
			end
			ST_RUN: begin
				cmd.issue    = 1'b1;
				cmd.first    = (k_q == i_q);
				cmd.dj_load  = (k_q == i_q);
				cmd.dim_addr = k_q + 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_EMIT: begin
				cmd.out_load = sts.out_free;
				cmd.cost_we  = sts.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			err_q   <= 1'b0;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			diag_q  <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (acc) begin
						if (last_dim) begin
							cnt_q <= '0;
							ovf_q <= 1'b0;
							if (err_now || cnt_q == CNT_W'(1)) begin
								err_q   <= err_now;
								state_q <= ST_SHORT;
							end else begin
								n_q     <= IDX_W'(cnt_q);
								i_q     <= '0;
								j_q     <= IDX_W'(1);
								diag_q  <= IDX_W'(1);
								state_q <= ST_DI;
							end
						end else if (!full)
							cnt_q <= cnt_q + 1'b1;
						else
							ovf_q <= 1'b1;
					end
				end
				ST_SHORT: begin
					if (sts.out_free)
						state_q <= ST_LOAD;
				end
				ST_DI: begin
					state_q <= ST_DJ;
				end
				ST_DJ: begin
					k_q     <= i_q;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (k_q == j_q - 1'b1)
						state_q <= ST_DRAIN;
					else
						k_q <= k_q + 1'b1;
				end
				ST_DRAIN: begin
					if (!sts.busy)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						if (j_q != n_q - 1'b1) begin
							i_q     <= i_q + 1'b1;
							j_q     <= j_q + 1'b1;
							state_q <= ST_DI;
						end else if (diag_q != n_q - 1'b1) begin
							diag_q  <= diag_q + 1'b1;
							i_q     <= '0;
							j_q     <= diag_q + 1'b1;
							state_q <= ST_DI;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_MATRICES + 1))
		else $error("dimension count past store depth");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result register overwritten while held");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cost_we |-> !sts.busy)
		else $error("cost written with split points still in flight");

	a_split_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (k_q >= i_q && k_q < j_q && j_q < n_q))
		else $error("split point outside its range");

	a_set_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && last_dim) |=> (cnt_q == '0 && !ovf_q))
		else $error("load state not cleared after last request");

endmodule

// ===== src/matrix_chain_order_dp.sv =====
// Matrix chain ordering by dynamic programming: top level.
// Depends on mcm_pkg, mcm_ctrl and mcm_dpath.
//
// Usage: send the chain's dimensions on the dim channel, one request per
// value (rows of the first matrix, then every column count); last_dim marks
// the final one. Values past MAX_MATRICES+1 are dropped and flag an error.
// After the last request the block stalls its input and computes; results
// leave on the res channel by diagonal, then by row, one per pair i<j, and
// last_result marks the whole-chain cost. A short or oversized set gives one
// result with size_error set; a single matrix gives one zero-cost result.
// Each pair (i,j) takes two dimension reads, then one split point per cycle
// through the multiply/add/compare pipeline, a drain of that pipeline, then
// one write-back. Pairs share that one pipeline, and the dimension store
// has a single read port.
// A stalled result holds the controller before its next write-back; the
// input is taken again as soon as the last result is in the output register.
// Reset clears the load count and state; no table needs clearing.
module matrix_chain_order_dp import mcm_pkg::*; #(
	parameter int MAX_MATRICES = DEF_MAX_MATRICES,
	parameter int DIM_WIDTH    = DEF_DIM_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      dim_valid,
	output logic      dim_stall,
	input  dim_item_t dim,
	output logic      res_valid,
	input  logic      res_stall,
	output result_t   res
);

	mcm_cmd_t cmd;
	mcm_sts_t sts;

	mcm_ctrl #(
		.MAX_MATRICES(MAX_MATRICES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.dim_valid(dim_valid),
		.last_dim (dim.last_dim),
		.dim_stall(dim_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	mcm_dpath #(
		.MAX_MATRICES(MAX_MATRICES),
		.DIM_WIDTH   (DIM_WIDTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.dim_value(dim.dim_value),
		.res_stall(res_stall),
		.res_valid(res_valid),
		.res      (res)
	);

endmodule

// ===== test/tb_matrix_chain_order_dp.sv =====
// Testbench for matrix_chain_order_dp: sends dimension chains and checks every result.
// A scoreboard class predicts the cost and split tables for each accepted chain.
// Depends on mcm_pkg and the matrix_chain_order_dp RTL.
module tb_matrix_chain_order_dp import mcm_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          MAX_MAT     = DEF_MAX_MATRICES;
	localparam int          ITEM_TARGET = 330;
	localparam int          DRAIN_WAIT  = 300;
	localparam int unsigned CYCLE_LIMIT = 400000;

	class chain_scoreboard;
		logic [DEF_DIM_WIDTH-1:0] dims [MAX_MAT+1];
		int unsigned loaded;
		bit          overflow;
		result_t     due[$];
		int          mismatches, checked, chains, rejected, full_chains;

		function logic [COST_W-1:0] sat_sum(logic [47:0] a, logic [47:0] b);
			logic [48:0] s;
			s = {1'b0, a} + {1'b0, b};
			return (s > COST_MAX) ? COST_MAX : s[COST_W-1:0];
		endfunction

		// store one dimension; on the closing one, solve the chain and queue its results
		function void note_dim(dim_item_t req);
			logic [COST_W-1:0] cost [MAX_MAT][MAX_MAT];
			logic [COST_W-1:0] best, cand;
			logic [47:0]       prod;
			int                n, j, bk;
			result_t           r;
			if (loaded < MAX_MAT + 1) begin
				dims[loaded] = req.dim_value;
				loaded++;
			end else begin
				overflow = 1'b1;
			end
			if (!req.last_dim)
				return;
			chains++;
			r = '0;
			r.last_result = 1'b1;
			if (overflow || loaded < 2) begin
				r.size_error = 1'b1;
				due.push_back(r);
				rejected++;
				overflow = 1'b0;
				loaded = 0;
				return;
			end
			n = loaded - 1;
			loaded = 0;
			if (n == 1) begin
				due.push_back(r);
				return;
			end
			if (n == MAX_MAT)
				full_chains++;
			for (int i = 0; i < n; i++)
				cost[i][i] = '0;
			for (int d = 1; d < n; d++) begin
				for (int i = 0; i + d < n; i++) begin
					j = i + d;
					best = '0;
					bk = i;
					for (int k = i; k < j; k++) begin
						prod = 48'(dims[i]) * 48'(dims[k+1]) * 48'(dims[j+1]);
						cand = sat_sum(48'(sat_sum(48'(cost[i][k]), 48'(cost[k+1][j]))), prod);
						// strict compare keeps the lowest k on ties
						if (k == i || cand < best) begin
							best = cand;
							bk = k;
						end
					end
					cost[i][j] = best;
					r = '0;
					r.row_index = IDX_W'(i);
					r.col_index = IDX_W'(j);
					r.min_cost = best;
					r.split_point = IDX_W'(bk);
					r.last_result = (d == n - 1);
					due.push_back(r);
				end
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			checked++;
			if (due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: row %0d col %0d cost %0d split %0d err %b last %b",
						got.row_index, got.col_index, got.min_cost, got.split_point,
						got.size_error, got.last_result);
				return;
			end
			want = due.pop_front();
			if (got.row_index !== want.row_index || got.col_index !== want.col_index ||
			    got.min_cost !== want.min_cost || got.split_point !== want.split_point ||
			    got.size_error !== want.size_error || got.last_result !== want.last_result) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result %0d wrong: expected row %0d col %0d cost %0d split %0d err %b last %b",
						checked, want.row_index, want.col_index, want.min_cost,
						want.split_point, want.size_error, want.last_result);
					$display("    got: row %0d col %0d cost %0d split %0d err %b last %b",
						got.row_index, got.col_index, got.min_cost, got.split_point,
						got.size_error, got.last_result);
				end
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      dim_valid = 1'b0;
	logic      dim_stall;
	dim_item_t dim       = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	result_t   res;

	chain_scoreboard sb = new();
	bit              calm;
	int              sent;
	int unsigned     cycles;

	matrix_chain_order_dp dut (
		.clk(clk),
		.arst_n(arst_n),
		.dim_valid(dim_valid),
		.dim_stall(dim_stall),
		.dim(dim),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, sb.due.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk)
		res_stall <= !calm && ($urandom_range(0, 99) < 18);

	// outputs are sampled mid-cycle; the handshake completes at the next rising edge
	always @(negedge clk)
		if (arst_n && res_valid && !res_stall)
			sb.check_result(res);

	task automatic send_dim(input logic [IN_DIM_W-1:0] v, input logic last);
		dim_item_t req;
		bit        taken;
		req.dim_value = v;
		req.last_dim = last;
		dim <= req;
		dim_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = !dim_stall;
			@(posedge clk);
		end while (!taken);
		sb.note_dim(req);
		sent++;
		if (!calm && $urandom_range(0, 99) < 18) begin
			dim_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic run_chain(input logic [IN_DIM_W-1:0] vals[$]);
		for (int d = 0; d < vals.size(); d++)
			send_dim(vals[d], d == vals.size() - 1);
	endtask

	task automatic drain();
		dim_valid <= 1'b0;
		do @(posedge clk); while (sb.due.size() != 0);
	endtask

	initial begin
		logic [IN_DIM_W-1:0] chain[$];
		int                  nd, pick, set_no;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: lone dimension, single matrix, max dims, textbook chain,
		// zero dims (zero cost), and an oversized chain
		chain = {12'd5};
		run_chain(chain);
		chain = {12'hFFF, 12'hFFF};
		run_chain(chain);
		chain = {12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF};
		run_chain(chain);
		chain = {12'd10, 12'd30, 12'd5, 12'd60};
		run_chain(chain);
		chain = {12'd0, 12'd3, 12'd0};
		run_chain(chain);
		chain = {};
		for (int d = 0; d < MAX_MAT + 2; d++)
			chain.push_back(IN_DIM_W'(d + 1));
		run_chain(chain);
		drain();

		set_no = 0;
		while (sent < ITEM_TARGET) begin
			calm = (set_no >= 14 && set_no < 24);
			if ($urandom_range(0, 99) < 12)
				nd = $urandom_range(0, 1) ? 1 : $urandom_range(MAX_MAT + 2, MAX_MAT + 4);
			else if ($urandom_range(0, 2) == 0)
				nd = MAX_MAT + 1;
			else
				nd = $urandom_range(2, MAX_MAT + 1);
			chain = {};
			for (int d = 0; d < nd; d++) begin
				pick = $urandom_range(0, 9);
				if (pick == 0)
					chain.push_back('0);
				else if (pick == 1)
					chain.push_back('1);
				else if (pick == 2)
					chain.push_back(IN_DIM_W'($urandom_range(1, 3)));
				else
					chain.push_back(IN_DIM_W'($urandom_range(0, 4095)));
			end
			run_chain(chain);
			set_no++;
			if (set_no == 10)
				drain();
		end
		calm = 1'b0;

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("%0d dimension requests in %0d chains (%0d of full length, %0d size errors)",
			sent, sb.chains, sb.full_chains, sb.rejected);
		$display("%0d results checked, %0d wrong or unexpected, %0d never arrived",
			sb.checked, sb.mismatches, sb.due.size());
		if (sb.mismatches == 0 && sb.due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
